[rtl/wsg_pkg.sv]
package wsg_pkg;

  localparam int unsigned PERIOD_MS_DEF            = 2000;
  localparam int unsigned SINE_QUARTER_ENTRIES_DEF = 1024;

  localparam int unsigned STEP_W  = 8;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned AMP_W   = 14;
  localparam int unsigned ANGLE_W = 15;
  localparam int unsigned SINE_W  = 15;  // Q15 table magnitude
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned DATA_W  = 32;

  localparam logic [AMP_W-1:0] AMP_RESET = AMP_W'(11520);

  typedef enum logic [MODE_W-1:0] {
    MODE_STOP = 2'd0,
    MODE_SINE = 2'd1,
    MODE_TRI  = 2'd2
  } mode_e;

  typedef enum logic [0:0] {
    REG_WAVE_MODE = 1'b0,
    REG_AMPLITUDE = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [MODE_W-1:0] wave_mode;
    logic [AMP_W-1:0]  amplitude;
  } cfg_t;

  typedef struct packed {
    logic              neg;
    logic [SINE_W-1:0] mag;
  } sine_word_t;

endpackage

[rtl/wsg_regs.sv]
module wsg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wsg_pkg::ADDR_W-1:0]   paddr,
  input  logic [wsg_pkg::DATA_W-1:0]   pwdata,
  output logic [wsg_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output wsg_pkg::cfg_t                cfg_o,
  output logic                         phase_clr_o
);
  import wsg_pkg::*;

  cfg_t     cfg_q, cfg_d;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = reg_idx_e'(paddr[ADDR_W-1]);

  always_comb begin
    cfg_d       = cfg_q;
    phase_clr_o = 1'b0;
    if (wr_en) begin
      case (idx)
        REG_WAVE_MODE: begin
          cfg_d.wave_mode = pwdata[MODE_W-1:0];
          phase_clr_o     = 1'b1;  // mode write restarts the phase
        end
        REG_AMPLITUDE: begin
          cfg_d.amplitude = pwdata[AMP_W-1:0];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_WAVE_MODE: prdata = DATA_W'(cfg_q.wave_mode);
      REG_AMPLITUDE: prdata = DATA_W'(cfg_q.amplitude);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wave_mode <= MODE_STOP;
      cfg_q.amplitude <= AMP_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/wsg_phase.sv]
module wsg_phase #(
  parameter int unsigned PeriodMs = wsg_pkg::PERIOD_MS_DEF,
  localparam int unsigned PhW     = $clog2(PeriodMs)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       acc_i,
  input  logic                       clr_i,
  input  logic [wsg_pkg::STEP_W-1:0] step_i,
  output logic [PhW-1:0]             phase_o,
  output logic [PhW-1:0]             phase_nxt_o
);
  import wsg_pkg::*;

  localparam int unsigned StepDepth = 1 << STEP_W;
  localparam logic [PhW:0] PeriodC  = (PhW+1)'(PeriodMs);

  logic [PhW-1:0] phase_q, phase_d;
  logic [PhW-1:0] step_mod [StepDepth];
  logic [PhW:0]   sum;

  // step reduced mod period, so one conditional subtract closes the wrap
  for (genvar g = 0; g < StepDepth; g++) begin : g_mod
    assign step_mod[g] = PhW'(g % PeriodMs);
  end

  assign sum         = {1'b0, phase_q} + {1'b0, step_mod[step_i]};
  assign phase_nxt_o = (sum >= PeriodC) ? PhW'(sum - PeriodC) : sum[PhW-1:0];

  always_comb begin
    phase_d = phase_q;
    if (clr_i) begin
      phase_d = '0;
    end else if (acc_i) begin
      phase_d = phase_nxt_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_d;
    end
  end

  assign phase_o = phase_q;

endmodule

[rtl/wsg_sine_rom.sv]
module wsg_sine_rom #(
  parameter int unsigned PeriodMs           = wsg_pkg::PERIOD_MS_DEF,
  parameter int unsigned SineQuarterEntries = wsg_pkg::SINE_QUARTER_ENTRIES_DEF,
  localparam int unsigned PhW               = $clog2(PeriodMs)
) (
  input  logic                clk_i,
  input  logic                rd_en_i,
  input  logic [PhW-1:0]      addr_i,
  output wsg_pkg::sine_word_t rd_o
);
  import wsg_pkg::*;

  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  // Q30 Taylor series, rounded to Q15 and capped
  function automatic logic [SINE_W-1:0] quarter_sine(input logic [63:0] idx);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] q15;
    x    = (HalfPiQ30 * idx) / 64'(SineQuarterEntries);
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - term;
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + term;
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - term;
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + term;
    term = ((term * x2) >> 30) / 64'd110; sum = sum - term;
    term = ((term * x2) >> 30) / 64'd156; sum = sum + term;
    term = ((term * x2) >> 30) / 64'd210; sum = sum - term;
    term = ((term * x2) >> 30) / 64'd272; sum = sum + term;
    q15  = (sum + 64'd16384) >> 15;
    if (q15 > 64'd32767) begin
      q15 = 64'd32767;
    end
    return q15[SINE_W-1:0];
  endfunction

  // one word per phase value: quadrant folding done here
  function automatic sine_word_t phase_word(input logic [63:0] c);
    logic [63:0] k;
    logic [63:0] quad;
    logic [63:0] r;
    sine_word_t  w;
    k     = (c * 64'd4 * 64'(SineQuarterEntries)) / 64'(PeriodMs);
    quad  = (k / 64'(SineQuarterEntries)) & 64'd3;
    r     = k % 64'(SineQuarterEntries);
    w.neg = quad[1];
    w.mag = quad[0] ? quarter_sine(64'(SineQuarterEntries) - r) : quarter_sine(r);
    return w;
  endfunction

  sine_word_t rom_mem [PeriodMs];
  sine_word_t rd_q;

  for (genvar g = 0; g < PeriodMs; g++) begin : g_rom
    localparam sine_word_t Word = phase_word(64'(g));
    assign rom_mem[g] = Word;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= rom_mem[addr_i];
    end
  end

  assign rd_o = rd_q;

endmodule

[rtl/wsg_scale.sv]
module wsg_scale #(
  parameter int unsigned PeriodMs = wsg_pkg::PERIOD_MS_DEF,
  localparam int unsigned PhW     = $clog2(PeriodMs)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  wsg_pkg::cfg_t                      cfg_i,
  input  logic                               s1_valid_i,
  output logic                               s1_ready_o,
  input  logic [PhW-1:0]                     phase_i,
  input  wsg_pkg::sine_word_t                sine_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [wsg_pkg::ANGLE_W-1:0] target_angle_o
);
  import wsg_pkg::*;

  localparam int unsigned W4     = PhW + 3;
  localparam int unsigned ProdW  = AMP_W + SINE_W;
  localparam int unsigned RecipW = ProdW - 1;
  localparam int unsigned EstW   = AMP_W + 1;
  localparam int unsigned RpW    = ProdW + RecipW;

  localparam logic [W4-1:0]     P1    = W4'(PeriodMs);
  localparam logic [W4-1:0]     P2    = W4'(2 * PeriodMs);
  localparam logic [W4-1:0]     P3    = W4'(3 * PeriodMs);
  localparam logic [W4-1:0]     P4    = W4'(4 * PeriodMs);
  localparam logic [ProdW-1:0]  PProd = ProdW'(PeriodMs);
  // floor(2^ProdW / P): estimate of N/P is low by at most one
  localparam logic [RecipW-1:0] Recip = RecipW'((64'd1 << ProdW) / PeriodMs);

  logic rdy2, rdy3, rdy4;

  // stage 1: triangle segment, operand select
  logic [W4-1:0]     c4, u_w;
  logic              tri_neg;
  logic [SINE_W-1:0] x1;
  logic              neg1;

  always_comb begin
    c4      = W4'({phase_i, 2'b00});
    u_w     = c4;
    tri_neg = 1'b0;
    if (c4 < P1) begin
      u_w     = c4;
      tri_neg = 1'b0;
    end else if (c4 < P3) begin
      if (c4 <= P2) begin
        u_w     = P2 - c4;
        tri_neg = 1'b0;
      end else begin
        u_w     = c4 - P2;
        tri_neg = 1'b1;
      end
    end else begin
      u_w     = P4 - c4;
      tri_neg = 1'b1;
    end
  end

  assign x1   = (cfg_i.wave_mode == MODE_SINE) ? sine_i.mag : SINE_W'(u_w);
  assign neg1 = (cfg_i.wave_mode == MODE_SINE) ? sine_i.neg : tri_neg;

  // stage 2: amplitude product
  logic             vld2_q;
  logic [ProdW-1:0] prod2_q;
  logic             neg2_q;

  // stage 3: reciprocal estimate
  logic             vld3_q;
  logic [ProdW-1:0] prod3_q;
  logic             neg3_q;
  logic [EstW-1:0]  est3_q;
  logic [RpW-1:0]   recip_prod;

  assign recip_prod = RpW'(prod2_q) * RpW'(Recip);

  // stage 4: correction, sign, mode gate
  logic [ProdW-1:0]   back, rem;
  logic [EstW-1:0]    tri_mag, sine_mag, mag;
  logic [ANGLE_W-1:0] mag_ext, ang_d;
  logic               out_vld_q;
  logic [ANGLE_W-1:0] ang_q;

  assign back     = ProdW'(est3_q) * PProd;
  assign rem      = prod3_q - back;
  assign tri_mag  = (rem >= PProd) ? (est3_q + 1'b1) : est3_q;
  assign sine_mag = EstW'(prod3_q[SINE_W +: AMP_W]);

  always_comb begin
    case (cfg_i.wave_mode)
      MODE_SINE: mag = sine_mag;
      MODE_TRI:  mag = tri_mag;
      default:   mag = '0;
    endcase
  end

  assign mag_ext = ANGLE_W'(mag);
  assign ang_d   = neg3_q ? (ANGLE_W'(0) - mag_ext) : mag_ext;

  assign rdy4       = !out_vld_q || !out_stall_i;
  assign rdy3       = !vld3_q || rdy4;
  assign rdy2       = !vld2_q || rdy3;
  assign s1_ready_o = rdy2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q    <= 1'b0;
      vld3_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (rdy2) begin
        vld2_q <= s1_valid_i;
      end
      if (rdy3) begin
        vld3_q <= vld2_q;
      end
      if (rdy4) begin
        out_vld_q <= vld3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && s1_valid_i) begin
      prod2_q <= ProdW'(cfg_i.amplitude) * ProdW'(x1);
      neg2_q  <= neg1;
    end
    if (rdy3 && vld2_q) begin
      prod3_q <= prod2_q;
      neg3_q  <= neg2_q;
      est3_q  <= recip_prod[ProdW +: EstW];
    end
    if (rdy4 && vld3_q) begin
      ang_q <= ang_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign target_angle_o = $signed(ang_q);

  logic [ANGLE_W-1:0] ang_abs;
  assign ang_abs = ang_q[ANGLE_W-1] ? (ANGLE_W'(0) - ang_q) : ang_q;

  a_mag_le_amp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (ang_abs <= ANGLE_W'(cfg_i.amplitude)))
    else $error("angle magnitude above amplitude");

  // the quotient estimate only fits its width for triangle products
  a_est_within_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld3_q && (cfg_i.wave_mode == MODE_TRI)) |-> (rem < (PProd + PProd)))
    else $error("reciprocal estimate off by more than one");

  a_stop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (cfg_i.wave_mode != MODE_SINE) && (cfg_i.wave_mode != MODE_TRI))
      |-> (ang_q == '0))
    else $error("nonzero angle in stop mode");

endmodule

[rtl/waveform_setpoint_generator_top.sv]
// Motion setpoint generator, sine or triangle.
// Input channel (in_valid_i / in_stall_o) carries one word per tick: step_ms_i,
// the milliseconds since the previous word. Output channel (out_valid_o /
// out_stall_i) returns one word per input: target_angle_o, signed, 1/16 deg.
// APB port: wave_mode at 0x0 (0 stop, 1 sine, 2 triangle; any write zeroes
// the phase), amplitude at 0x4. Write only while the pipeline is empty.
// Throughput: one word per cycle while out_stall_i is low. Each word passes
// the phase update and sine ROM read, the amplitude multiply, the
// reciprocal multiply for the triangle divide, then the output register.
// The sine shape is held in a PeriodMs-word ROM indexed by phase, read
// through a register loaded in the same cycle the phase register updates.
// Each stage holds while the one after it is full and stalled, so bubbles
// are squeezed out; in_stall_o rises only when every stage holds a word.
// Reset: pipeline empty, stop mode, amplitude 11520, phase 0.
module waveform_setpoint_generator_top #(
  parameter int unsigned PeriodMs           = wsg_pkg::PERIOD_MS_DEF,
  parameter int unsigned SineQuarterEntries = wsg_pkg::SINE_QUARTER_ENTRIES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [wsg_pkg::STEP_W-1:0]         step_ms_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [wsg_pkg::ANGLE_W-1:0] target_angle_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [wsg_pkg::ADDR_W-1:0]         paddr,
  input  logic [wsg_pkg::DATA_W-1:0]         pwdata,
  output logic [wsg_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);
  import wsg_pkg::*;

  localparam int unsigned PhW = $clog2(PeriodMs);

  cfg_t           cfg;
  logic           phase_clr;
  logic           vld1_q;
  logic           s1_ready, ready0, acc;
  logic [PhW-1:0] phase, phase_nxt;
  sine_word_t     sine_word;

  assign ready0     = !vld1_q || s1_ready;
  assign acc        = in_valid_i && ready0;
  assign in_stall_o = !ready0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else if (ready0) begin
      vld1_q <= in_valid_i;
    end
  end

  wsg_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .cfg_o       (cfg),
    .phase_clr_o (phase_clr)
  );

  wsg_phase #(
    .PeriodMs (PeriodMs)
  ) u_phase (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .clr_i       (phase_clr),
    .step_i      (step_ms_i),
    .phase_o     (phase),
    .phase_nxt_o (phase_nxt)
  );

  wsg_sine_rom #(
    .PeriodMs           (PeriodMs),
    .SineQuarterEntries (SineQuarterEntries)
  ) u_rom (
    .clk_i   (clk_i),
    .rd_en_i (acc),
    .addr_i  (phase_nxt),
    .rd_o    (sine_word)
  );

  wsg_scale #(
    .PeriodMs (PeriodMs)
  ) u_scale (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .s1_valid_i     (vld1_q),
    .s1_ready_o     (s1_ready),
    .phase_i        (phase),
    .sine_i         (sine_word),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .target_angle_o (target_angle_o)
  );

endmodule
